FILE: hdl/hsv2rgb_pkg.sv
// hsv to rgb pixel converter: shared types, constants and helpers
// no dependencies; used by hsv2rgb_div and hsv_to_rgb_pixel
`timescale 1ns / 1ps

package hsv2rgb_pkg;

   // fixed-point scale constants
   localparam int unsigned DEG_PER_SECTOR = 60;
   localparam int unsigned UNIT           = 255;
   localparam int unsigned FULL_TURN      = 360;
   localparam int unsigned SECTOR_SCALE   = UNIT * DEG_PER_SECTOR;

   // reciprocal of 60 in 16 fraction bits, exact for hue up to 511
   localparam int unsigned RECIP_DEG_SHIFT = 16;
   localparam logic [10:0] RECIP_DEG       = 11'd1093;

   // floor of 2^32 / 15300, quotient comes out low by at most one
   localparam int unsigned RECIP_SCALE_SHIFT = 32;
   localparam logic [18:0] RECIP_SCALE       = 19'd280716;

   // widths
   localparam int unsigned HUE_W    = 9;
   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned SECTOR_W = 4;
   localparam int unsigned REM_W    = 6;
   localparam int unsigned SPROD_W  = 14;
   localparam int unsigned NUM_W    = 22;

   // sector codes
   localparam logic [SECTOR_W-1:0] SECTOR_RED_YELLOW    = 4'd0;
   localparam logic [SECTOR_W-1:0] SECTOR_YELLOW_GREEN  = 4'd1;
   localparam logic [SECTOR_W-1:0] SECTOR_GREEN_CYAN    = 4'd2;
   localparam logic [SECTOR_W-1:0] SECTOR_CYAN_BLUE     = 4'd3;
   localparam logic [SECTOR_W-1:0] SECTOR_BLUE_MAGENTA  = 4'd4;

   typedef struct packed {
      logic [HUE_W-1:0]  hue_deg;
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] value_level;
   } hsv_pixel_type;

   typedef struct packed {
      logic [CHAN_W-1:0]   red;
      logic [CHAN_W-1:0]   green;
      logic [CHAN_W-1:0]   blue;
      logic [3*CHAN_W-1:0] grb_word;
   } rgb_pixel_type;

   // floor(x / 255) for x below 65280
   function automatic logic [CHAN_W-1:0] div_unit(input logic [15:0] x);
      logic [16:0] sum;
      begin
         sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
         div_unit = sum[15:8];
      end
   endfunction

endpackage

FILE: hdl/hsv2rgb_div.sv
// two-stage divide by 15300: reciprocal multiply, then one correction step
// depends on hsv2rgb_pkg
`timescale 1ns / 1ps

module hsv2rgb_div (
   input  logic                             clock,
   input  logic [hsv2rgb_pkg::NUM_W-1:0]    num,
   output logic [hsv2rgb_pkg::CHAN_W-1:0]   quot
);

   logic [hsv2rgb_pkg::NUM_W+18:0]  prod;
   logic [hsv2rgb_pkg::CHAN_W-1:0]  approx_in;
   logic [hsv2rgb_pkg::CHAN_W-1:0]  approx_ff;
   logic [hsv2rgb_pkg::NUM_W-1:0]   num_ff;
   logic [hsv2rgb_pkg::NUM_W-1:0]   back;
   logic [hsv2rgb_pkg::NUM_W-1:0]   resid;
   logic [hsv2rgb_pkg::CHAN_W-1:0]  quot_in;
   logic [hsv2rgb_pkg::CHAN_W-1:0]  quot_ff;

   // approximate quotient, never above the true one
   assign prod      = num * hsv2rgb_pkg::RECIP_SCALE;
   assign approx_in = prod[hsv2rgb_pkg::RECIP_SCALE_SHIFT +: hsv2rgb_pkg::CHAN_W];

   always_ff @(posedge clock) begin
      approx_ff <= approx_in;
      num_ff    <= num;
   end

   // add one when the remainder still holds a whole divisor
   assign back  = approx_ff * hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::SECTOR_SCALE);
   assign resid = num_ff - back;
   always_comb begin
      if (resid >= hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::SECTOR_SCALE)) begin
         quot_in = approx_ff + 8'd1;
      end else begin
         quot_in = approx_ff;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

FILE: hdl/hsv_to_rgb_pixel.sv
// hsv to rgb pixel converter top level, six-stage pipeline
// depends on hsv2rgb_pkg and hsv2rgb_div
`timescale 1ns / 1ps

// Converts one hsv pixel per clock into 8-bit red, green, blue and a packed
// grb word (green 23..16, red 15..8, blue 7..0). A request is taken on every
// clock where start is high; busy is always low since the pipeline never
// backs up. Each result appears on rsp_pixel for exactly one cycle with
// rsp_valid high, in request order. The receiver cannot stall the block,
// so it must take every strobed result. The pipeline holds three multiply
// stages, then the two divide-by-15300 stages and the output register;
// throughput is one pixel per clock.

module hsv_to_rgb_pixel (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  hsv2rgb_pkg::hsv_pixel_type   req_pixel,
   output logic                         rsp_valid,
   output hsv2rgb_pkg::rgb_pixel_type   rsp_pixel
);

   localparam int unsigned CW = hsv2rgb_pkg::CHAN_W;

   // valid bits, one per stage
   logic [5:0] valid_in;
   logic [5:0] valid_ff;

   // stage 1: sector and remainder
   logic [hsv2rgb_pkg::HUE_W-1:0]     hue;
   logic [19:0]                       hue_prod;
   logic [hsv2rgb_pkg::SECTOR_W-1:0]  sector_in;
   logic [9:0]                        sector_back;
   logic [9:0]                        rem_full;
   logic [hsv2rgb_pkg::SECTOR_W-1:0]  s1_sector_ff;
   logic [hsv2rgb_pkg::REM_W-1:0]     s1_rem_ff;
   logic [CW-1:0]                     s1_sat_ff;
   logic [CW-1:0]                     s1_val_ff;

   // stage 2: saturation products
   logic [hsv2rgb_pkg::REM_W-1:0]     rem_inv;
   logic [hsv2rgb_pkg::SECTOR_W-1:0]  s2_sector_ff;
   logic [hsv2rgb_pkg::SPROD_W-1:0]   s2_srem_ff;
   logic [hsv2rgb_pkg::SPROD_W-1:0]   s2_sinv_ff;
   logic [15:0]                       s2_pnum_ff;
   logic                              s2_grey_ff;
   logic [CW-1:0]                     s2_val_ff;

   // stage 3: q and t numerators, p
   logic [hsv2rgb_pkg::SPROD_W-1:0]   q_factor;
   logic [hsv2rgb_pkg::SPROD_W-1:0]   t_factor;
   logic [hsv2rgb_pkg::NUM_W-1:0]     s3_qnum_ff;
   logic [hsv2rgb_pkg::NUM_W-1:0]     s3_tnum_ff;
   logic [CW-1:0]                     s3_p_ff;
   logic [hsv2rgb_pkg::SECTOR_W-1:0]  s3_sector_ff;
   logic                              s3_grey_ff;
   logic [CW-1:0]                     s3_val_ff;

   // stages 4 and 5: sideband alongside the dividers
   logic [CW-1:0]                     s4_p_ff;
   logic [hsv2rgb_pkg::SECTOR_W-1:0]  s4_sector_ff;
   logic                              s4_grey_ff;
   logic [CW-1:0]                     s4_val_ff;
   logic [CW-1:0]                     s5_p_ff;
   logic [hsv2rgb_pkg::SECTOR_W-1:0]  s5_sector_ff;
   logic                              s5_grey_ff;
   logic [CW-1:0]                     s5_val_ff;
   logic [CW-1:0]                     q_val;
   logic [CW-1:0]                     t_val;

   // stage 6: channel select
   logic [CW-1:0]                     red_sel;
   logic [CW-1:0]                     green_sel;
   logic [CW-1:0]                     blue_sel;
   hsv2rgb_pkg::rgb_pixel_type        rsp_in;
   hsv2rgb_pkg::rgb_pixel_type        rsp_ff;

   assign busy = 1'b0;

   // valid chain
   assign valid_in = {valid_ff[4:0], start & ~busy};
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // full turn wraps to zero, then divide by 60 through the reciprocal
   always_comb begin
      if (req_pixel.hue_deg == hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::FULL_TURN)) begin
         hue = '0;
      end else begin
         hue = req_pixel.hue_deg;
      end
   end
   assign hue_prod    = hue * hsv2rgb_pkg::RECIP_DEG;
   assign sector_in   = hue_prod[hsv2rgb_pkg::RECIP_DEG_SHIFT +: hsv2rgb_pkg::SECTOR_W];
   assign sector_back = sector_in * 10'(hsv2rgb_pkg::DEG_PER_SECTOR);
   assign rem_full    = {1'b0, hue} - sector_back;

   always_ff @(posedge clock) begin
      s1_sector_ff <= sector_in;
      s1_rem_ff    <= rem_full[hsv2rgb_pkg::REM_W-1:0];
      s1_sat_ff    <= req_pixel.saturation;
      s1_val_ff    <= req_pixel.value_level;
   end

   // saturation times remainder, its complement, and the p numerator
   assign rem_inv = hsv2rgb_pkg::REM_W'(hsv2rgb_pkg::DEG_PER_SECTOR) - s1_rem_ff;
   always_ff @(posedge clock) begin
      s2_sector_ff <= s1_sector_ff;
      s2_srem_ff   <= s1_sat_ff * s1_rem_ff;
      s2_sinv_ff   <= s1_sat_ff * rem_inv;
      s2_pnum_ff   <= s1_val_ff * (CW'(hsv2rgb_pkg::UNIT) - s1_sat_ff);
      s2_grey_ff   <= (s1_sat_ff == '0);
      s2_val_ff    <= s1_val_ff;
   end

   // value times the scaled q and t factors
   assign q_factor = hsv2rgb_pkg::SPROD_W'(hsv2rgb_pkg::SECTOR_SCALE) - s2_srem_ff;
   assign t_factor = hsv2rgb_pkg::SPROD_W'(hsv2rgb_pkg::SECTOR_SCALE) - s2_sinv_ff;
   always_ff @(posedge clock) begin
      s3_qnum_ff   <= s2_val_ff * q_factor;
      s3_tnum_ff   <= s2_val_ff * t_factor;
      s3_p_ff      <= hsv2rgb_pkg::div_unit(s2_pnum_ff);
      s3_sector_ff <= s2_sector_ff;
      s3_grey_ff   <= s2_grey_ff;
      s3_val_ff    <= s2_val_ff;
   end

   // divide q and t numerators by 15300
   hsv2rgb_div q_div (
      .clock (clock),
      .num   (s3_qnum_ff),
      .quot  (q_val)
   );

   hsv2rgb_div t_div (
      .clock (clock),
      .num   (s3_tnum_ff),
      .quot  (t_val)
   );

   // sideband delay matching the dividers
   always_ff @(posedge clock) begin
      s4_p_ff      <= s3_p_ff;
      s4_sector_ff <= s3_sector_ff;
      s4_grey_ff   <= s3_grey_ff;
      s4_val_ff    <= s3_val_ff;
      s5_p_ff      <= s4_p_ff;
      s5_sector_ff <= s4_sector_ff;
      s5_grey_ff   <= s4_grey_ff;
      s5_val_ff    <= s4_val_ff;
   end

   // six-sector table, grey when saturation is zero
   always_comb begin
      if (s5_grey_ff) begin
         red_sel   = s5_val_ff;
         green_sel = s5_val_ff;
         blue_sel  = s5_val_ff;
      end else begin
         unique case (s5_sector_ff)
            hsv2rgb_pkg::SECTOR_RED_YELLOW: begin
               red_sel   = s5_val_ff;
               green_sel = t_val;
               blue_sel  = s5_p_ff;
            end
            hsv2rgb_pkg::SECTOR_YELLOW_GREEN: begin
               red_sel   = q_val;
               green_sel = s5_val_ff;
               blue_sel  = s5_p_ff;
            end
            hsv2rgb_pkg::SECTOR_GREEN_CYAN: begin
               red_sel   = s5_p_ff;
               green_sel = s5_val_ff;
               blue_sel  = t_val;
            end
            hsv2rgb_pkg::SECTOR_CYAN_BLUE: begin
               red_sel   = s5_p_ff;
               green_sel = q_val;
               blue_sel  = s5_val_ff;
            end
            hsv2rgb_pkg::SECTOR_BLUE_MAGENTA: begin
               red_sel   = t_val;
               green_sel = s5_p_ff;
               blue_sel  = s5_val_ff;
            end
            default: begin
               red_sel   = s5_val_ff;
               green_sel = s5_p_ff;
               blue_sel  = q_val;
            end
         endcase
      end
   end

   // output register and grb packing
   always_comb begin
      rsp_in.red      = red_sel;
      rsp_in.green    = green_sel;
      rsp_in.blue     = blue_sel;
      rsp_in.grb_word = {green_sel, red_sel, blue_sel};
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff[5];
   assign rsp_pixel = rsp_ff;

endmodule
